// ===== rtl/tlbrr_pkg.sv =====
// Shared types and constants of the fully associative TLB with LRU or random replacement.
// Used by every module of the block; depends on nothing.
package tlbrr_pkg;

    localparam int ENTRIES_DEF    = 32;
    localparam int PAGE_BITS_DEF  = 20;
    localparam int FRAME_BITS_DEF = 20;

    localparam int SEED_BITS      = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;
    localparam int MOD_DIGIT_BITS = 8;

    localparam logic [SEED_BITS-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [SEED_BITS-1:0] SEED_RESET = 32'h0000_0001;

    localparam logic [CFG_INDEX_BITS-1:0] REG_REPLACE_POLICY = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANDOM_SEED    = 1'b1;

    localparam logic POLICY_RANDOM = 1'b0;
    localparam logic POLICY_LRU    = 1'b1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        logic capture;
        logic select;
        logic reduce;
        logic fetch;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic need_random;
        logic reduce_last;
    } stat_t;

endpackage

// ===== rtl/tlbrr_mod.sv =====
// Residue unit: reduces a 32-bit word modulo a constant, eight bits per step, MSB first.
// Depends on tlbrr_pkg.
module tlbrr_mod #(
    parameter int MODULUS = tlbrr_pkg::ENTRIES_DEF,
    localparam int REM_BITS = $clog2(MODULUS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [tlbrr_pkg::SEED_BITS-1:0] value,
    input  logic                           step,
    output logic [REM_BITS-1:0]            rem,
    output logic                           last
);
    import tlbrr_pkg::*;

    localparam int STEPS    = SEED_BITS / MOD_DIGIT_BITS;
    localparam int CNT_BITS = $clog2(STEPS);
    localparam logic [REM_BITS:0] MOD_T = (REM_BITS + 1)'(MODULUS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(STEPS - 1);

    logic [SEED_BITS-1:0] value_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [REM_BITS-1:0]  rem_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [REM_BITS:0]    trial;

    always_comb
    begin
        rem_next = rem_reg;
        trial    = '0;
        for (int k = 0; k < MOD_DIGIT_BITS; k++)
        begin
            trial = {rem_next, value_reg[SEED_BITS-1-k]};
            if (trial >= MOD_T)
            begin
                trial = trial - MOD_T;
            end
            rem_next = trial[REM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            value_reg <= value_reg << MOD_DIGIT_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign rem  = rem_reg;
    assign last = (cnt_reg == CNT_LAST);

endmodule

// ===== rtl/tlbrr_dp.sv =====
// Datapath: entry lanes with parallel compare, recency ranks, victim LFSR and result registers.
// Depends on tlbrr_pkg and tlbrr_mod.
module tlbrr_dp #(
    parameter int ENTRIES    = tlbrr_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS  = tlbrr_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS = tlbrr_pkg::FRAME_BITS_DEF,
    localparam int SLOT_BITS = $clog2(ENTRIES)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tlbrr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tlbrr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [1:0]                          opcode,
    input  logic [PAGE_BITS-1:0]                virt_page,
    input  logic [FRAME_BITS-1:0]               phys_frame,
    input  tlbrr_pkg::cmd_t                     cmd,
    output tlbrr_pkg::stat_t                    stat,
    output logic                                done,
    output logic                                found,
    output logic [FRAME_BITS-1:0]               frame_out,
    output logic [SLOT_BITS-1:0]                slot_used
);
    import tlbrr_pkg::*;

    localparam logic [SLOT_BITS-1:0] LRU_RANK = SLOT_BITS'(ENTRIES - 1);

    logic [ENTRIES-1:0]    valid_reg;
    logic [PAGE_BITS-1:0]  page_reg [ENTRIES];
    logic [FRAME_BITS-1:0] frame_reg [ENTRIES];
    logic [SLOT_BITS-1:0]  rank_reg [ENTRIES];

    logic                  policy_reg;
    logic [SEED_BITS-1:0]  lfsr_reg;
    logic [SEED_BITS-1:0]  lfsr_next;

    logic [1:0]            op_reg;
    logic [PAGE_BITS-1:0]  req_page_reg;
    logic [FRAME_BITS-1:0] req_frame_reg;
    logic [ENTRIES-1:0]    sel_vec_reg;
    logic                  full_reg;
    logic                  rand_req_reg;
    logic                  found_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [SLOT_BITS-1:0]  rank_sel_reg;
    logic [FRAME_BITS-1:0] frame_sel_reg;

    logic                  done_reg;
    logic                  found_out_reg;
    logic [FRAME_BITS-1:0] frame_out_reg;
    logic [SLOT_BITS-1:0]  slot_out_reg;

    logic [ENTRIES-1:0]    hit_vec;
    logic [ENTRIES-1:0]    clr_vec;
    logic [ENTRIES-1:0]    lru_vec;
    logic [ENTRIES-1:0]    sel_vec;
    logic                  full;
    logic [ENTRIES-1:0]    first_hot;
    logic [SLOT_BITS-1:0]  slot_enc;
    logic [SLOT_BITS-1:0]  fetch_idx;
    logic [ENTRIES-1:0]    lane_sel;
    logic [SLOT_BITS-1:0]  mod_rem;
    logic                  mod_last;
    logic                  is_lookup;
    logic                  is_insert;
    logic                  is_clear;

    tlbrr_mod #(
        .MODULUS (ENTRIES)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.select),
        .value (lfsr_next),
        .step  (cmd.reduce),
        .rem   (mod_rem),
        .last  (mod_last)
    );

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (page_reg[i] == virt_page);
            clr_vec[i] = hit_vec[i] && (frame_reg[i] == phys_frame);
            lru_vec[i] = valid_reg[i] && (rank_reg[i] == LRU_RANK);
        end
        full = &valid_reg;
        case (opcode)
            OP_LOOKUP: sel_vec = hit_vec;
            OP_INSERT: sel_vec = full ? lru_vec : ~valid_reg;
            OP_CLEAR:  sel_vec = clr_vec;
            default:   sel_vec = '0;
        endcase
    end

    always_comb
    begin
        first_hot = sel_vec_reg & (~sel_vec_reg + ENTRIES'(1));
        slot_enc  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (first_hot[i])
            begin
                slot_enc = slot_enc | SLOT_BITS'(i);
            end
        end
    end

    always_comb
    begin
        lfsr_next = {1'b0, lfsr_reg[SEED_BITS-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        if (lfsr_next == '0)
        begin
            lfsr_next = SEED_RESET;
        end
    end

    assign fetch_idx = rand_req_reg ? mod_rem : slot_reg;
    assign is_lookup = (op_reg == OP_LOOKUP);
    assign is_insert = (op_reg == OP_INSERT);
    assign is_clear  = (op_reg == OP_CLEAR);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            lane_sel[i] = (SLOT_BITS'(i) == slot_reg);
        end
    end

    // configuration and victim generator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_LRU;
            lfsr_reg   <= SEED_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_REPLACE_POLICY: policy_reg <= cfg_data[0];
                REG_RANDOM_SEED:    lfsr_reg   <= (cfg_data == '0) ? SEED_RESET : cfg_data;
                default:            ;
            endcase
        end
        else if (cmd.select && rand_req_reg)
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rand_req_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
            if (cmd.capture)
            begin
                rand_req_reg <= (opcode == OP_INSERT) && full && (policy_reg == POLICY_RANDOM);
            end
        end
    end

    // request capture, selection and fetch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= opcode;
            req_page_reg  <= virt_page;
            req_frame_reg <= phys_frame;
            sel_vec_reg   <= sel_vec;
            full_reg      <= full;
        end
        if (cmd.select)
        begin
            slot_reg  <= slot_enc;
            found_reg <= |sel_vec_reg;
        end
        else if (cmd.fetch)
        begin
            slot_reg      <= fetch_idx;
            rank_sel_reg  <= rank_reg[fetch_idx];
            frame_sel_reg <= frame_reg[fetch_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.update)
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    if (!full_reg)
                    begin
                        valid_reg[slot_reg] <= 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    if (found_reg)
                    begin
                        valid_reg[slot_reg] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // lane updates: contents and recency
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            if (lane_sel[i])
                            begin
                                rank_reg[i] <= '0;
                            end
                            else if (valid_reg[i] && (rank_reg[i] < rank_sel_reg))
                            begin
                                rank_reg[i] <= rank_reg[i] + SLOT_BITS'(1);
                            end
                        end
                    end
                    OP_INSERT:
                    begin
                        if (lane_sel[i])
                        begin
                            page_reg[i]  <= req_page_reg;
                            frame_reg[i] <= req_frame_reg;
                            rank_reg[i]  <= '0;
                        end
                        else if (valid_reg[i] && (!full_reg || (rank_reg[i] < rank_sel_reg)))
                        begin
                            rank_reg[i] <= rank_reg[i] + SLOT_BITS'(1);
                        end
                    end
                    OP_CLEAR:
                    begin
                        if (found_reg && !lane_sel[i] && valid_reg[i]
                            && (rank_reg[i] > rank_sel_reg))
                        begin
                            rank_reg[i] <= rank_reg[i] - SLOT_BITS'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            found_out_reg <= (is_lookup || is_clear) && found_reg;
            frame_out_reg <= (is_lookup && found_reg) ? frame_sel_reg : '0;
            slot_out_reg  <= (is_insert || ((is_lookup || is_clear) && found_reg))
                             ? slot_reg : '0;
        end
    end

    assign stat.need_random = rand_req_reg;
    assign stat.reduce_last = mod_last;

    assign done      = done_reg;
    assign found     = found_out_reg;
    assign frame_out = frame_out_reg;
    assign slot_used = slot_out_reg;

endmodule

// ===== rtl/tlbrr_ctrl.sv =====
// Controller: one-hot sequencer of capture, select, reduce, fetch and update steps.
// Depends on tlbrr_pkg.
module tlbrr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  tlbrr_pkg::stat_t stat,
    output tlbrr_pkg::cmd_t  cmd,
    output logic             busy
);
    import tlbrr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SELECT = 5'b00010,
        S_REDUCE = 5'b00100,
        S_FETCH  = 5'b01000,
        S_UPDATE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        case (state_reg)
            S_IDLE:   state_next = start ? S_SELECT : S_IDLE;
            S_SELECT: state_next = stat.need_random ? S_REDUCE : S_FETCH;
            S_REDUCE: state_next = stat.reduce_last ? S_FETCH : S_REDUCE;
            S_FETCH:  state_next = S_UPDATE;
            S_UPDATE: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.select  = (state_reg == S_SELECT);
    assign cmd.reduce  = (state_reg == S_REDUCE);
    assign cmd.fetch   = (state_reg == S_FETCH);
    assign cmd.update  = (state_reg == S_UPDATE);

endmodule

// ===== rtl/tlb_lru_random_replace.sv =====
// Top level of the fully associative TLB with LRU or random replacement.
// Depends on tlbrr_pkg, tlbrr_ctrl and tlbrr_dp.
//
// Requests (opcode, virt_page, phys_frame) transfer at a rising edge with start high and
// busy low. Opcodes: lookup, insert, clear; any other code gives an all-zero result.
// Each request gives one result (found, frame_out, slot_used), shown for exactly one
// cycle with done high; the receiver cannot stall it.
// Sequence: capture, select, fetch, update; done rises at the same edge at which busy falls,
// and no new request transfers while busy is high. An insert into a full table under
// random policy adds reduce steps after select: the residue of the LFSR state modulo the
// entry count is formed eight bits per cycle.
// The entry compare runs over all lanes in parallel in the cycle of the transfer.
// Configuration: cfg_write with cfg_index 0 sets the policy (0 random, 1 LRU), index 1
// loads the seed into the LFSR (zero loads 1). Write only while busy is low.
// Reset: all entries invalid, policy LRU, LFSR state 1; no clearing pass.
module tlb_lru_random_replace #(
    parameter int ENTRIES    = tlbrr_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS  = tlbrr_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS = tlbrr_pkg::FRAME_BITS_DEF,
    localparam int SLOT_BITS = $clog2(ENTRIES)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tlbrr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tlbrr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic [PAGE_BITS-1:0]                virt_page,
    input  logic [FRAME_BITS-1:0]               phys_frame,
    output logic                                done,
    output logic                                found,
    output logic [FRAME_BITS-1:0]               frame_out,
    output logic [SLOT_BITS-1:0]                slot_used
);
    import tlbrr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tlbrr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tlbrr_dp #(
        .ENTRIES    (ENTRIES),
        .PAGE_BITS  (PAGE_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .opcode     (opcode),
        .virt_page  (virt_page),
        .phys_frame (phys_frame),
        .cmd        (cmd),
        .stat       (stat),
        .done       (done),
        .found      (found),
        .frame_out  (frame_out),
        .slot_used  (slot_used)
    );

endmodule

// ===== bench/tlb_lru_random_replace_test.sv =====
// Self-checking bench for tlb_lru_random_replace: a directed request table, then random
// phases under both replacement policies, each result checked against the table's expected
// value where one is given, else against a shadow TLB. Depends on tlbrr_pkg and the RTL.
module tlb_lru_random_replace_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbrr_pkg::*;

    localparam int ENTRIES       = ENTRIES_DEF;
    localparam int PAGE_BITS     = PAGE_BITS_DEF;
    localparam int FRAME_BITS    = FRAME_BITS_DEF;
    localparam int SLOT_BITS     = $clog2(ENTRIES);
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int DIRECTED_ROWS = 21;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 150;
    localparam int POOL_DEPTH    = 64;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_LIMIT   = 400;

    typedef struct packed {
        logic                  found;
        logic [FRAME_BITS-1:0] frame;
        logic [SLOT_BITS-1:0]  slot;
    } tlb_result_t;

    typedef struct packed {
        logic [1:0]            op;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        logic                  typed;
        tlb_result_t           result;
    } request_row_t;

    typedef struct packed {
        logic        policy;
        logic [31:0] seed;
        logic        seed_random;
        logic [6:0]  pool_size;
        logic [6:0]  insert_pct;
        logic [6:0]  clear_pct;
        logic        idling;
    } phase_plan_t;

    localparam tlb_result_t NO_RESULT = '0;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                opcode = '0;
    logic [PAGE_BITS-1:0]      virt_page = '0;
    logic [FRAME_BITS-1:0]     phys_frame = '0;
    logic                      done;
    logic                      found;
    logic [FRAME_BITS-1:0]     frame_out;
    logic [SLOT_BITS-1:0]      slot_used;

    logic                  shadow_valid [ENTRIES];
    logic [PAGE_BITS-1:0]  shadow_page  [ENTRIES];
    logic [FRAME_BITS-1:0] shadow_frame [ENTRIES];
    int unsigned           shadow_rank  [ENTRIES];
    logic                  shadow_policy = POLICY_LRU;
    logic [31:0]           shadow_lfsr = SEED_RESET;

    tlb_result_t           pending_results [$];
    int                    mismatches = 0;
    bit                    idling_on = 1'b1;

    request_row_t          directed_rows [DIRECTED_ROWS];
    phase_plan_t           phase_plans [PHASES];
    logic [PAGE_BITS-1:0]  pool_page  [POOL_DEPTH];
    logic [FRAME_BITS-1:0] pool_frame [POOL_DEPTH];

    tlb_lru_random_replace dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .virt_page  (virt_page),
        .phys_frame (phys_frame),
        .done       (done),
        .found      (found),
        .frame_out  (frame_out),
        .slot_used  (slot_used)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void promote_entry(input int k);
        int unsigned r;
        r = shadow_rank[k];
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && i != k && shadow_rank[i] < r)
                shadow_rank[i]++;
        shadow_rank[k] = 0;
    endfunction

    function automatic tlb_result_t predict_translation(input logic [1:0] op,
                                                        input logic [PAGE_BITS-1:0] page,
                                                        input logic [FRAME_BITS-1:0] frame);
        tlb_result_t res;
        bit          placed;
        int          victim;
        int unsigned best;
        int unsigned gone;
        res = NO_RESULT;
        placed = 1'b0;
        victim = 0;
        best = 0;
        case (op)
            OP_LOOKUP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!res.found && shadow_valid[i] && shadow_page[i] == page)
                    begin
                        res.found = 1'b1;
                        res.frame = shadow_frame[i];
                        res.slot = i[SLOT_BITS-1:0];
                        promote_entry(i);
                    end
            end
            OP_INSERT:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!placed && !shadow_valid[i])
                    begin
                        for (int j = 0; j < ENTRIES; j++)
                            if (shadow_valid[j])
                                shadow_rank[j]++;
                        shadow_valid[i] = 1'b1;
                        shadow_page[i] = page;
                        shadow_frame[i] = frame;
                        shadow_rank[i] = 0;
                        res.slot = i[SLOT_BITS-1:0];
                        placed = 1'b1;
                    end
                if (!placed)
                begin
                    if (shadow_policy == POLICY_LRU)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (shadow_rank[i] >= best)
                            begin
                                best = shadow_rank[i];
                                victim = i;
                            end
                    end
                    else
                    begin
                        shadow_lfsr = (shadow_lfsr >> 1) ^ (shadow_lfsr[0] ? LFSR_TAPS : 32'h0);
                        if (shadow_lfsr == 32'h0)
                            shadow_lfsr = 32'd1;
                        victim = int'(shadow_lfsr % ENTRIES);
                    end
                    shadow_page[victim] = page;
                    shadow_frame[victim] = frame;
                    promote_entry(victim);
                    res.slot = victim[SLOT_BITS-1:0];
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!res.found && shadow_valid[i] && shadow_page[i] == page
                        && shadow_frame[i] == frame)
                    begin
                        gone = shadow_rank[i];
                        shadow_valid[i] = 1'b0;
                        for (int j = 0; j < ENTRIES; j++)
                            if (shadow_valid[j] && shadow_rank[j] > gone)
                                shadow_rank[j]--;
                        res.found = 1'b1;
                        res.slot = i[SLOT_BITS-1:0];
                    end
            end
            default:
            begin
                res = NO_RESULT;
            end
        endcase
        return res;
    endfunction

    task automatic issue_request(input logic [1:0] op, input logic [PAGE_BITS-1:0] page,
                                 input logic [FRAME_BITS-1:0] frame, input logic typed,
                                 input tlb_result_t typed_result);
        tlb_result_t want;
        if (idling_on && $urandom_range(99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        virt_page <= page;
        phys_frame <= frame;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = predict_translation(op, page, frame);
        if (typed)
            want = typed_result;
        pending_results.push_back(want);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (index == REG_REPLACE_POLICY)
            shadow_policy = value[0];
        else
            shadow_lfsr = (value == '0) ? 32'd1 : value;
    endtask

    always @(posedge clk)
    begin : result_check
        tlb_result_t got;
        tlb_result_t want;
        if (rst_n && done)
        begin
            got.found = found;
            got.frame = frame_out;
            got.slot = slot_used;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result found=%0d frame=%h slot=%0d",
                             $realtime, got.found, got.frame, got.slot);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.frame !== want.frame
                    || got.slot !== want.slot)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: expected %0d %h %0d, got %0d %h %0d",
                                 $realtime, want.found, want.frame, want.slot,
                                 got.found, got.frame, got.slot);
                end
            end
        end
    end

    initial
    begin
        #500_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        phase_plan_t           plan;
        logic [1:0]            op;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        logic [31:0]           rand_word;
        logic [31:0]           seed;
        int                    pick;
        int                    roll;
        int                    waited;

        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_page[i] = '0;
            shadow_frame[i] = '0;
            shadow_rank[i] = 0;
        end

        directed_rows = '{
            '{OP_LOOKUP,  20'h00000, 20'h00000, 1'b1, NO_RESULT},
            '{OP_LOOKUP,  20'hFFFFF, 20'hFFFFF, 1'b1, NO_RESULT},
            '{OP_CLEAR,   20'h00000, 20'h00000, 1'b1, NO_RESULT},
            '{OP_UNKNOWN, 20'hFFFFF, 20'hFFFFF, 1'b1, NO_RESULT},
            '{OP_INSERT,  20'hFFFFF, 20'hFFFFF, 1'b1, '{1'b0, 20'h00000, 5'd0}},
            '{OP_INSERT,  20'h00000, 20'h00000, 1'b1, '{1'b0, 20'h00000, 5'd1}},
            '{OP_LOOKUP,  20'hFFFFF, 20'h00000, 1'b1, '{1'b1, 20'hFFFFF, 5'd0}},
            '{OP_LOOKUP,  20'h00000, 20'hFFFFF, 1'b1, '{1'b1, 20'h00000, 5'd1}},
            '{OP_INSERT,  20'hFFFFF, 20'h5A5A5, 1'b0, NO_RESULT},
            '{OP_LOOKUP,  20'hFFFFF, 20'h00000, 1'b0, NO_RESULT},
            '{OP_CLEAR,   20'hFFFFF, 20'h5A5A5, 1'b0, NO_RESULT},
            '{OP_CLEAR,   20'h00000, 20'h00001, 1'b1, NO_RESULT},
            '{OP_UNKNOWN, 20'h00000, 20'h00000, 1'b1, NO_RESULT},
            '{OP_LOOKUP,  20'h00000, 20'h00000, 1'b0, NO_RESULT},
            '{OP_CLEAR,   20'hFFFFF, 20'hFFFFF, 1'b0, NO_RESULT},
            '{OP_INSERT,  20'hA5A5A, 20'h0F0F0, 1'b0, NO_RESULT},
            '{OP_INSERT,  20'h12345, 20'hFEDCB, 1'b0, NO_RESULT},
            '{OP_LOOKUP,  20'h12345, 20'h00000, 1'b0, NO_RESULT},
            '{OP_LOOKUP,  20'h54321, 20'h00000, 1'b1, NO_RESULT},
            '{OP_CLEAR,   20'h00000, 20'h00000, 1'b0, NO_RESULT},
            '{OP_CLEAR,   20'h00000, 20'h00000, 1'b1, NO_RESULT}
        };

        phase_plans = '{
            '{POLICY_LRU,    32'h0000_0001, 1'b0, 7'd48, 7'd50, 7'd15, 1'b1},
            '{POLICY_RANDOM, 32'h0000_0000, 1'b0, 7'd48, 7'd50, 7'd15, 1'b1},
            '{POLICY_RANDOM, 32'hFFFF_FFFF, 1'b0, 7'd8,  7'd45, 7'd20, 1'b0},
            '{POLICY_LRU,    32'h0000_0000, 1'b1, 7'd64, 7'd30, 7'd40, 1'b1},
            '{POLICY_RANDOM, 32'h8000_0000, 1'b0, 7'd40, 7'd50, 7'd15, 1'b1},
            '{POLICY_LRU,    32'h0000_0000, 1'b1, 7'd4,  7'd40, 7'd30, 1'b1},
            '{POLICY_RANDOM, 32'h0000_0000, 1'b1, 7'd48, 7'd55, 7'd10, 1'b1},
            '{POLICY_LRU,    32'h0000_0001, 1'b0, 7'd36, 7'd50, 7'd15, 1'b0},
            '{POLICY_RANDOM, 32'h0000_0001, 1'b0, 7'd48, 7'd50, 7'd15, 1'b1}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            issue_request(directed_rows[r].op, directed_rows[r].page,
                          directed_rows[r].frame, directed_rows[r].typed,
                          directed_rows[r].result);

        for (int p = 0; p < PHASES; p++)
        begin
            plan = phase_plans[p];
            wait_idle();
            write_register(REG_REPLACE_POLICY, {{(CFG_DATA_BITS-1){1'b0}}, plan.policy});
            seed = plan.seed_random ? $urandom() : plan.seed;
            write_register(REG_RANDOM_SEED, seed);
            idling_on = plan.idling;

            for (int k = 0; k < POOL_DEPTH; k++)
            begin
                rand_word = $urandom();
                pool_page[k] = (k == 0) ? '0 : (k == 1) ? '1 : rand_word[PAGE_BITS-1:0];
                rand_word = $urandom();
                pool_frame[k] = (k == 1) ? '1 : rand_word[FRAME_BITS-1:0];
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < plan.insert_pct)
                    op = OP_INSERT;
                else if (roll < plan.insert_pct + plan.clear_pct)
                    op = OP_CLEAR;
                else if (roll < 95)
                    op = OP_LOOKUP;
                else
                    op = OP_UNKNOWN;
                if ($urandom_range(99) < 85)
                begin
                    pick = $urandom_range(plan.pool_size - 1);
                    page = pool_page[pick];
                    frame = pool_frame[pick];
                    rand_word = $urandom();
                    if (op == OP_CLEAR && $urandom_range(99) < 20)
                        frame = rand_word[FRAME_BITS-1:0];
                end
                else
                begin
                    rand_word = $urandom();
                    page = rand_word[PAGE_BITS-1:0];
                    rand_word = $urandom();
                    frame = rand_word[FRAME_BITS-1:0];
                end
                issue_request(op, page, frame, 1'b0, NO_RESULT);
            end
        end

        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (12) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
